// ===== design/tpv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpv_pkg: shared types and constants of the trajectory point validator
// Register indexes, error codes, the configuration bundle, the per-item
// pipeline tag and the flags each axis lane reports to the merge stage.
// ----------------------------------------------------------------------------
package tpv_pkg;

  localparam int NUM_AXES  = 3;
  localparam int FIELD_W   = 32;   // each value field on the input bus
  localparam int STAMP_W   = 32;
  localparam int IN_DATA_W = 10 * FIELD_W;
  localparam int OUT_DATA_W = 24;  // 20 bits of fields, padded to bytes
  localparam int IDX_W     = 16;   // reported point index
  localparam int LIM_W     = 31;   // limit and tolerance registers
  localparam int CFG_IDX_W = 3;
  localparam int TOL_PROD_W = 64;  // 2*tol*dt

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_EN = 3'd0,
    REG_MAX_SPEED = 3'd1,
    REG_ACCEL_EN = 3'd2,
    REG_MAX_ACCEL = 3'd3,
    REG_DERIV_EN = 3'd4,
    REG_POS_TOL = 3'd5,
    REG_VEL_TOL = 3'd6
  } reg_idx_t;

  // verdict codes
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_BAD   = 3'd1,
    ERR_TIME  = 3'd2,
    ERR_LIMIT = 3'd3,
    ERR_DERIV = 3'd4
  } err_code_t;

  typedef struct packed {
    logic             spd_en;
    logic [LIM_W-1:0] spd_lim;
    logic             acc_en;
    logic [LIM_W-1:0] max_accel;
    logic             der_en;
    logic [LIM_W-1:0] pos_tol;
    logic [LIM_W-1:0] vel_tol;
  } cfg_t;

  // travels with an item down the pipeline
  typedef struct packed {
    logic             fin;      // last point of the trajectory
    logic             bad;      // source flagged a non-finite value
    logic             tfail;    // time not rising
    logic             pair_ok;  // pair test applies to this item
    logic [IDX_W-1:0] idx;      // this point's index
    logic [IDX_W-1:0] lower;    // lower point of the pair
  } meta_t;

  typedef struct packed {
    logic limit;  // speed or acceleration over its limit
    logic deriv;  // pair inconsistency on this axis
  } lane_flags_t;

endpackage

// ===== design/tpv_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpv_lane: one axis of the point checker
// Keeps the axis' previous point, checks the speed and acceleration limits
// and tests position and velocity rates against the neighbour means, in a
// four-stage pipeline that advances on adv.
// ----------------------------------------------------------------------------
module tpv_lane #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                adv,
  input  logic                                accept,
  input  logic [tpv_pkg::FIELD_W-1:0]         pos,
  input  logic [tpv_pkg::FIELD_W-1:0]         vel,
  input  logic [tpv_pkg::FIELD_W-1:0]         acc,
  input  logic [tpv_pkg::STAMP_W-1:0]         dt_s1,
  input  logic [tpv_pkg::TOL_PROD_W-1:0]      tol_p_s3,
  input  logic [tpv_pkg::TOL_PROD_W-1:0]      tol_v_s3,
  input  tpv_pkg::cfg_t                       cfg,
  output tpv_pkg::lane_flags_t                flags
);

  localparam int VW  = VALUE_WIDTH;
  localparam int DW  = VW + 1;                     // difference or sum
  localparam int D2W = DW + 1;                     // doubled difference
  localparam int TW  = tpv_pkg::STAMP_W + 1;       // dt as signed
  localparam int PW  = DW + TW;                    // sum * dt
  localparam int GW  = PW + 1;                     // gap before magnitude
  localparam int CWD = (GW > tpv_pkg::TOL_PROD_W ? GW : tpv_pkg::TOL_PROD_W) + 1;
  localparam int MW  = (VW > tpv_pkg::LIM_W ? VW : tpv_pkg::LIM_W);

  logic signed [VW-1:0] pos_s, vel_s, acc_s;
  logic signed [VW-1:0] prev_pos_r, prev_vel_r, prev_acc_r;

  logic signed [DW-1:0] dp_r, sv_r, dv_r, sa_r;
  logic        [VW-1:0] mv_r, ma_r;

  logic signed [TW-1:0]  dt_s;
  logic signed [PW-1:0]  pp_r, vp_r;
  logic signed [D2W-1:0] dp2_r, dv2_r;
  logic                  lim2_r;

  logic signed [GW-1:0]  pg_r, vg_r;
  logic                  lim3_r;

  logic signed [CWD-1:0] pgx, vgx, tp, tv;
  logic                  pfail, vfail;
  tpv_pkg::lane_flags_t  flags_r;

  // values taken at VALUE_WIDTH bits, sign at the top bit
  assign pos_s = $signed(VW'(pos));
  assign vel_s = $signed(VW'(vel));
  assign acc_s = $signed(VW'(acc));

  // previous point of this axis
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_pos_r <= pos_s;
      prev_vel_r <= vel_s;
      prev_acc_r <= acc_s;
    end
  end

  // stage 1: differences, sums, magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      dp_r <= DW'(pos_s) - DW'(prev_pos_r);
      sv_r <= DW'(vel_s) + DW'(prev_vel_r);
      dv_r <= DW'(vel_s) - DW'(prev_vel_r);
      sa_r <= DW'(acc_s) + DW'(prev_acc_r);
      mv_r <= vel_s[VW-1] ? $unsigned(-vel_s) : $unsigned(vel_s);
      ma_r <= acc_s[VW-1] ? $unsigned(-acc_s) : $unsigned(acc_s);
    end
  end

  // stage 2: sum * dt, limit compares
  assign dt_s = $signed({1'b0, dt_s1});

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r   <= PW'(sv_r) * PW'(dt_s);
      vp_r   <= PW'(sa_r) * PW'(dt_s);
      dp2_r  <= D2W'(dp_r) <<< 1;
      dv2_r  <= D2W'(dv_r) <<< 1;
      lim2_r <= (cfg.spd_en && (MW'(mv_r) > MW'(cfg.spd_lim)))
             || (cfg.acc_en && (MW'(ma_r) > MW'(cfg.max_accel)));
    end
  end

  // stage 3: signed gap 2*diff - sum*dt
  always_ff @(posedge clk) begin
    if (adv) begin
      pg_r   <= GW'(dp2_r) - GW'(pp_r);
      vg_r   <= GW'(dv2_r) - GW'(vp_r);
      lim3_r <= lim2_r;
    end
  end

  // stage 4: |gap| > T as gap > T or gap < -T
  always_comb begin
    pgx   = CWD'(pg_r);
    vgx   = CWD'(vg_r);
    tp    = $signed(CWD'(tol_p_s3));
    tv    = $signed(CWD'(tol_v_s3));
    pfail = (pgx > tp) || (pgx < -tp);
    vfail = (vgx > tv) || (vgx < -tv);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_r.deriv <= pfail || vfail;
      flags_r.limit <= lim3_r;
    end
  end

  assign flags = flags_r;

endmodule

// ===== design/tpv_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpv_merge: combines the lane flags and keeps the trajectory verdict
// Records the first point error and the first pair error in item order and
// loads the output register on the final point, then clears for the next
// trajectory.
// ----------------------------------------------------------------------------
module tpv_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            take,
  input  tpv_pkg::meta_t                                  meta,
  input  tpv_pkg::lane_flags_t [tpv_pkg::NUM_AXES-1:0]    flags,
  input  logic                                            out_tready,
  output logic                                            out_tvalid,
  output logic [tpv_pkg::OUT_DATA_W-1:0]                  out_tdata
);

  tpv_pkg::err_code_t              pcode_r, pcode_nxt, code_now;
  logic [tpv_pkg::IDX_W-1:0]       pat_r, pat_nxt;
  logic                            dseen_r, dseen_nxt;
  logic [tpv_pkg::IDX_W-1:0]       dat_r, dat_nxt;
  logic                            any_lim, any_der;

  logic                            out_valid_r;
  logic                            ok_nxt;
  tpv_pkg::err_code_t              code_nxt;
  logic [tpv_pkg::IDX_W-1:0]       idx_nxt;
  logic                            ok_r;
  tpv_pkg::err_code_t              code_r;
  logic [tpv_pkg::IDX_W-1:0]       idx_r;

  // merge lane flags
  always_comb begin
    any_lim = 1'b0;
    any_der = 1'b0;
    for (int k = 0; k < tpv_pkg::NUM_AXES; k++) begin
      any_lim = any_lim | flags[k].limit;
      any_der = any_der | flags[k].deriv;
    end
  end

  // point error by priority, then first-error bookkeeping
  always_comb begin
    if (meta.bad)        code_now = tpv_pkg::ERR_BAD;
    else if (meta.tfail) code_now = tpv_pkg::ERR_TIME;
    else if (any_lim)    code_now = tpv_pkg::ERR_LIMIT;
    else                 code_now = tpv_pkg::ERR_NONE;

    pcode_nxt = pcode_r;
    pat_nxt   = pat_r;
    if ((pcode_r == tpv_pkg::ERR_NONE) && (code_now != tpv_pkg::ERR_NONE)) begin
      pcode_nxt = code_now;
      pat_nxt   = meta.idx;
    end

    dseen_nxt = dseen_r;
    dat_nxt   = dat_r;
    if (!dseen_r && meta.pair_ok && any_der) begin
      dseen_nxt = 1'b1;
      dat_nxt   = meta.lower;
    end

    // verdict
    if (pcode_nxt != tpv_pkg::ERR_NONE) begin
      ok_nxt   = 1'b0;
      code_nxt = pcode_nxt;
      idx_nxt  = pat_nxt;
    end else if (dseen_nxt) begin
      ok_nxt   = 1'b0;
      code_nxt = tpv_pkg::ERR_DERIV;
      idx_nxt  = dat_nxt;
    end else begin
      ok_nxt   = 1'b1;
      code_nxt = tpv_pkg::ERR_NONE;
      idx_nxt  = '0;
    end
  end

  // trajectory state, cleared after the final point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcode_r <= tpv_pkg::ERR_NONE;
      pat_r   <= '0;
      dseen_r <= 1'b0;
      dat_r   <= '0;
    end else if (take) begin
      if (meta.fin) begin
        pcode_r <= tpv_pkg::ERR_NONE;
        pat_r   <= '0;
        dseen_r <= 1'b0;
        dat_r   <= '0;
      end else begin
        pcode_r <= pcode_nxt;
        pat_r   <= pat_nxt;
        dseen_r <= dseen_nxt;
        dat_r   <= dat_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && meta.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && meta.fin) begin
      ok_r   <= ok_nxt;
      code_r <= code_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, idx_r, code_r, ok_r};

endmodule

// ===== design/trajectory_point_validator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_point_validator_unit: 3-axis trajectory point checker
// Takes one point per item on the in_ stream and gives one verdict per
// trajectory on the out_ stream, on the point marked by in_tlast.
//
// Use: write the limit and tolerance registers through cfg_ while idle,
// then stream the points. Each point is checked for a flagged bad value,
// a time stamp not above the previous one, and speed or acceleration over
// the limits; neighbouring points are checked for position and velocity
// rates that stray from the mean of their derivatives by more than the
// tolerance. The first point error wins; otherwise the first pair error.
// Throughput: one point per cycle while in_tready is high. The three axis
// lanes run side by side through a four-stage pipeline whose second stage
// holds the (sum * dt) multipliers; the merge stage then loads the output
// register, and out_tvalid rises once the final point has been taken there.
// Reset clears valid bits, point count, configuration and trajectory state.
// A stalled receiver holds the result; points keep being accepted until a
// further final point reaches the merge stage, then in_tready drops until
// the waiting result is taken.
// ----------------------------------------------------------------------------
module trajectory_point_validator_unit #(
  parameter int MAX_POINTS  = 65536,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // stamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  input  logic [tpv_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tuser,   // bad_value
  input  logic                                in_tlast,   // final_point
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // ok, error_code[2:0], error_index[15:0], zero padding
  output logic [tpv_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [tpv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpv_pkg::LIM_W-1:0]           cfg_wdata
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  tpv_pkg::cfg_t                cfg_r;
  logic                         accept, adv, take;
  logic [CW-1:0]                count_r, idx_sat;
  logic [tpv_pkg::STAMP_W-1:0]  stamp, prev_stamp_r, dt_r;
  logic [tpv_pkg::TOL_PROD_W-1:0] tolp2_r, tolv2_r, tolp3_r, tolv3_r;
  logic                         v1_r, v2_r, v3_r, v4_r;
  tpv_pkg::meta_t               meta_in, m1_r, m2_r, m3_r, m4_r;
  tpv_pkg::lane_flags_t [tpv_pkg::NUM_AXES-1:0] lane_flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpv_pkg::REG_SPEED_EN:  cfg_r.spd_en    <= cfg_wdata[0];
        tpv_pkg::REG_MAX_SPEED: cfg_r.spd_lim   <= cfg_wdata;
        tpv_pkg::REG_ACCEL_EN:  cfg_r.acc_en    <= cfg_wdata[0];
        tpv_pkg::REG_MAX_ACCEL: cfg_r.max_accel <= cfg_wdata;
        tpv_pkg::REG_DERIV_EN:  cfg_r.der_en    <= cfg_wdata[0];
        tpv_pkg::REG_POS_TOL:   cfg_r.pos_tol   <= cfg_wdata;
        tpv_pkg::REG_VEL_TOL:   cfg_r.vel_tol   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline moves unless a final item is blocked behind a waiting result
  assign adv       = !(v4_r && m4_r.fin && out_tvalid && !out_tready);
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;
  assign take      = adv && v4_r;

  assign stamp = in_tdata[tpv_pkg::STAMP_W-1:0];

  // front end: index, time order, pair applicability
  always_comb begin
    idx_sat = (count_r < CW'(MAX_POINTS - 1)) ? count_r : CW'(MAX_POINTS - 1);
    meta_in.fin     = in_tlast;
    meta_in.bad     = in_tuser;
    meta_in.tfail   = (count_r != '0) && (stamp <= prev_stamp_r);
    meta_in.pair_ok = (count_r != '0) && cfg_r.der_en && (stamp > prev_stamp_r);
    meta_in.idx     = tpv_pkg::IDX_W'(idx_sat);
    meta_in.lower   = tpv_pkg::IDX_W'(count_r - CW'(1));
  end

  // point count, saturating, cleared after the final point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      if (in_tlast)                         count_r <= '0;
      else if (count_r != CW'(MAX_POINTS))  count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) prev_stamp_r <= stamp;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // item tags, dt and tolerance products
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r    <= meta_in;
      m2_r    <= m1_r;
      m3_r    <= m2_r;
      m4_r    <= m3_r;
      dt_r    <= stamp - prev_stamp_r;
      tolp2_r <= tpv_pkg::TOL_PROD_W'({cfg_r.pos_tol, 1'b0})
               * tpv_pkg::TOL_PROD_W'(dt_r);
      tolv2_r <= tpv_pkg::TOL_PROD_W'({cfg_r.vel_tol, 1'b0})
               * tpv_pkg::TOL_PROD_W'(dt_r);
      tolp3_r <= tolp2_r;
      tolv3_r <= tolv2_r;
    end
  end

  // one lane per axis
  for (genvar k = 0; k < tpv_pkg::NUM_AXES; k++) begin : g_lane
    tpv_lane #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lane (
      .clk      (clk),
      .adv      (adv),
      .accept   (accept),
      .pos      (in_tdata[tpv_pkg::FIELD_W*(1+k) +: tpv_pkg::FIELD_W]),
      .vel      (in_tdata[tpv_pkg::FIELD_W*(4+k) +: tpv_pkg::FIELD_W]),
      .acc      (in_tdata[tpv_pkg::FIELD_W*(7+k) +: tpv_pkg::FIELD_W]),
      .dt_s1    (dt_r),
      .tol_p_s3 (tolp3_r),
      .tol_v_s3 (tolv3_r),
      .cfg      (cfg_r),
      .flags    (lane_flags[k])
    );
  end

  tpv_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .meta       (m4_r),
    .flags      (lane_flags),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // a fresh result comes only from a final item at the merge stage
  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v4_r && m4_r.fin))
    else $error("result without a final item");

  // count restarts after the final point
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (count_r == '0))
    else $error("point count not cleared after final point");

  // ok and error code agree
  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == tpv_pkg::ERR_NONE)))
    else $error("ok flag disagrees with error code");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the trajectory point validator
// Streams trajectories of 3-axis points into the block and predicts the
// verdict of each trajectory with a behavioural model of the point checks
// and the neighbour-pair rate checks. Each verdict on the out_ stream is
// compared field by field with the oldest prediction. Directed tests cover
// the verdict codes, limit and tolerance extremes and register changes
// within a trajectory; random trajectories follow under changing register
// settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_PTS      = 65536;
  localparam int IDX_TOP      = MAX_PTS - 1;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 12;    // output latency plus margin
  localparam logic [tpv_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // not a register
  localparam logic [tpv_pkg::LIM_W-1:0]     LIM_MAX   = '1;

  // one point as it travels on the in_ stream
  typedef struct packed {
    logic [tpv_pkg::STAMP_W-1:0]                             stamp;
    logic [tpv_pkg::NUM_AXES-1:0][tpv_pkg::FIELD_W-1:0]      pos, vel, acc;
    logic                                                    bad;
    logic                                                    fin;
  } point_t;

  // one trajectory verdict
  typedef struct packed {
    logic                      ok;
    tpv_pkg::err_code_t        code;
    logic [tpv_pkg::IDX_W-1:0] index;
  } verdict_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  // stamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  logic [tpv_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           in_tuser   = 1'b0;   // bad_value
  logic                           in_tlast   = 1'b0;   // final_point
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // ok, error_code[2:0], error_index[15:0], zero padding
  logic [tpv_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [tpv_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tpv_pkg::LIM_W-1:0]      cfg_wdata  = '0;

  trajectory_point_validator_unit #(
    .MAX_POINTS (MAX_PTS),
    .VALUE_WIDTH(tpv_pkg::FIELD_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model state: registers and the running trajectory
  tpv_pkg::cfg_t                                      model_cfg  = '0;
  logic [tpv_pkg::STAMP_W-1:0]                        prev_stamp = '0;
  logic [tpv_pkg::NUM_AXES-1:0][tpv_pkg::FIELD_W-1:0] prev_pos   = '0;
  logic [tpv_pkg::NUM_AXES-1:0][tpv_pkg::FIELD_W-1:0] prev_vel   = '0;
  logic [tpv_pkg::NUM_AXES-1:0][tpv_pkg::FIELD_W-1:0] prev_acc   = '0;
  int unsigned                                        pt_count   = 0;
  tpv_pkg::err_code_t                                 pt_err     = tpv_pkg::ERR_NONE;
  logic [tpv_pkg::IDX_W-1:0]                          pt_err_at  = '0;
  bit                                                 pair_seen  = 1'b0;
  logic [tpv_pkg::IDX_W-1:0]                          pair_at    = '0;

  verdict_t    verdict_q[$];
  verdict_t    want;
  int          fail_count = 0;
  int unsigned cycles     = 0;
  bit          quiet      = 1'b0;   // no idling on either side

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 2);
    if (r < 94) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // receiver back-pressure
  initial begin
    forever begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 300)) @(negedge clk);
      else repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!quiet) begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  function automatic longint mag32(logic [tpv_pkg::FIELD_W-1:0] x);
    longint s;
    s = longint'($signed(x));
    return (s < 0) ? -s : s;
  endfunction

  // exact |2*diff - sum*dt| > 2*tol*dt
  function automatic bit rate_gap_over(longint diff, longint sum, longint unsigned dt,
                                       logic [tpv_pkg::LIM_W-1:0] tol);
    logic signed [127:0] d, s, t, lim, g;
    d   = diff;
    s   = sum;
    t   = $signed({64'd0, dt});
    lim = $signed({97'd0, tol});
    g   = 2 * d - s * t;
    if (g < 0) g = -g;
    lim = 2 * lim * t;
    return g > lim;
  endfunction

  // advance the trajectory model by one accepted point
  task automatic advance_trajectory(input point_t p);
    int unsigned        idx, lower;
    tpv_pkg::err_code_t code;
    longint unsigned    dt;
    bit                 fail;
    verdict_t           v;
    idx = (pt_count < IDX_TOP) ? pt_count : IDX_TOP;
    // first point error wins
    if (pt_err == tpv_pkg::ERR_NONE) begin
      code = tpv_pkg::ERR_NONE;
      if (p.bad) begin
        code = tpv_pkg::ERR_BAD;
      end else if (pt_count > 0 && p.stamp <= prev_stamp) begin
        code = tpv_pkg::ERR_TIME;
      end else begin
        for (int k = 0; k < tpv_pkg::NUM_AXES; k++) begin
          if (model_cfg.spd_en && mag32(p.vel[k]) > longint'(model_cfg.spd_lim))
            code = tpv_pkg::ERR_LIMIT;
          if (model_cfg.acc_en && mag32(p.acc[k]) > longint'(model_cfg.max_accel))
            code = tpv_pkg::ERR_LIMIT;
        end
      end
      if (code != tpv_pkg::ERR_NONE) begin
        pt_err    = code;
        pt_err_at = idx[tpv_pkg::IDX_W-1:0];
      end
    end
    // neighbour-pair rates, only on a rising pair
    if (pt_count > 0 && model_cfg.der_en && !pair_seen && p.stamp > prev_stamp) begin
      dt   = p.stamp - prev_stamp;
      fail = 1'b0;
      for (int k = 0; k < tpv_pkg::NUM_AXES; k++) begin
        if (rate_gap_over(longint'($signed(p.pos[k])) - longint'($signed(prev_pos[k])),
                          longint'($signed(p.vel[k])) + longint'($signed(prev_vel[k])),
                          dt, model_cfg.pos_tol))
          fail = 1'b1;
        if (rate_gap_over(longint'($signed(p.vel[k])) - longint'($signed(prev_vel[k])),
                          longint'($signed(p.acc[k])) + longint'($signed(prev_acc[k])),
                          dt, model_cfg.vel_tol))
          fail = 1'b1;
      end
      if (fail) begin
        lower     = pt_count - 1;
        pair_seen = 1'b1;
        pair_at   = (lower < IDX_TOP) ? lower[tpv_pkg::IDX_W-1:0]
                                      : IDX_TOP[tpv_pkg::IDX_W-1:0];
      end
    end
    prev_stamp = p.stamp;
    prev_pos   = p.pos;
    prev_vel   = p.vel;
    prev_acc   = p.acc;
    if (pt_count < MAX_PTS) pt_count++;
    // verdict on the final point, then a fresh trajectory
    if (p.fin) begin
      if (pt_err != tpv_pkg::ERR_NONE) v = '{ok: 1'b0, code: pt_err, index: pt_err_at};
      else if (pair_seen) v = '{ok: 1'b0, code: tpv_pkg::ERR_DERIV, index: pair_at};
      else v = '{ok: 1'b1, code: tpv_pkg::ERR_NONE, index: '0};
      verdict_q.push_back(v);
      prev_stamp = '0;
      prev_pos   = '0;
      prev_vel   = '0;
      prev_acc   = '0;
      pt_count   = 0;
      pt_err     = tpv_pkg::ERR_NONE;
      pt_err_at  = '0;
      pair_seen  = 1'b0;
      pair_at    = '0;
    end
  endtask

  // verdict checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.ok) begin
          $display("%0t: ok expected %0d got %0d", $time, want.ok, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[3:1] !== want.code) begin
          $display("%0t: error_code expected %0d got %0d", $time, want.code,
                   out_tdata[3:1]);
          fail_count++;
        end
        if (out_tdata[19:4] !== want.index) begin
          $display("%0t: error_index expected %0d got %0d", $time, want.index,
                   out_tdata[19:4]);
          fail_count++;
        end
      end
    end
  end

  // send one point; entered and left at a falling edge
  task automatic send_point(input point_t p);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {p.acc, p.vel, p.pos, p.stamp};
    in_tuser  <= p.bad;
    in_tlast  <= p.fin;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    advance_trajectory(p);
    @(negedge clk);
  endtask

  // hold the sender until every verdict is in and the pipeline is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [tpv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpv_pkg::LIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      tpv_pkg::REG_SPEED_EN:  model_cfg.spd_en    = val[0];
      tpv_pkg::REG_MAX_SPEED: model_cfg.spd_lim   = val;
      tpv_pkg::REG_ACCEL_EN:  model_cfg.acc_en    = val[0];
      tpv_pkg::REG_MAX_ACCEL: model_cfg.max_accel = val;
      tpv_pkg::REG_DERIV_EN:  model_cfg.der_en    = val[0];
      tpv_pkg::REG_POS_TOL:   model_cfg.pos_tol   = val;
      tpv_pkg::REG_VEL_TOL:   model_cfg.vel_tol   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // enable word with random upper bits
  function automatic logic [tpv_pkg::LIM_W-1:0] en_word(bit en);
    logic [31:0] r;
    r = $urandom;
    return {r[tpv_pkg::LIM_W-2:0], en};
  endfunction

  task automatic configure(input bit s_en, input logic [tpv_pkg::LIM_W-1:0] ms,
                           input bit a_en, input logic [tpv_pkg::LIM_W-1:0] ma,
                           input bit d_en, input logic [tpv_pkg::LIM_W-1:0] ptol,
                           input logic [tpv_pkg::LIM_W-1:0] vtol);
    wait_idle();
    write_reg(tpv_pkg::REG_SPEED_EN, en_word(s_en));
    write_reg(tpv_pkg::REG_MAX_SPEED, ms);
    write_reg(tpv_pkg::REG_ACCEL_EN, en_word(a_en));
    write_reg(tpv_pkg::REG_MAX_ACCEL, ma);
    write_reg(tpv_pkg::REG_DERIV_EN, en_word(d_en));
    write_reg(tpv_pkg::REG_POS_TOL, ptol);
    write_reg(tpv_pkg::REG_VEL_TOL, vtol);
  endtask

  // limit or tolerance: zero, full scale, wide random or near the data
  function automatic logic [tpv_pkg::LIM_W-1:0] pick_limit(int unsigned span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LIM_MAX;
    if (r == 2) return tpv_pkg::LIM_W'($urandom_range(0, 32'h7fff_ffff));
    return tpv_pkg::LIM_W'($urandom_range(0, span));
  endfunction

  function automatic point_t point_at(logic [tpv_pkg::STAMP_W-1:0] stamp,
                                      logic [tpv_pkg::FIELD_W-1:0] pos,
                                      logic [tpv_pkg::FIELD_W-1:0] vel,
                                      logic [tpv_pkg::FIELD_W-1:0] acc,
                                      logic bad, logic fin);
    point_t p;
    p.stamp = stamp;
    p.pos   = {tpv_pkg::NUM_AXES{pos}};
    p.vel   = {tpv_pkg::NUM_AXES{vel}};
    p.acc   = {tpv_pkg::NUM_AXES{acc}};
    p.bad   = bad;
    p.fin   = fin;
    return p;
  endfunction

  function automatic longint jitter(int pct, int span);
    if ($urandom_range(0, 99) < pct)
      return longint'($urandom_range(0, 2 * span)) - span;
    return 0;
  endfunction

  // all checks off after reset: extremes pass
  task automatic test_reset_defaults();
    send_point(point_at(0, 0, 0, 0, 0, 1));
    send_point(point_at(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
    send_point(point_at(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 1));
  endtask

  // bad value and time order, first error wins
  task automatic test_point_errors();
    send_point(point_at(5, 0, 0, 0, 1, 1));
    // bad value beats time not rising
    send_point(point_at(5, 0, 0, 0, 0, 0));
    send_point(point_at(4, 0, 0, 0, 1, 1));
    // stamp wrap is not rising; later bad value loses
    send_point(point_at(32'hffff_ffff, 0, 0, 0, 0, 0));
    send_point(point_at(0, 0, 0, 0, 0, 0));
    send_point(point_at(1, 0, 0, 0, 1, 1));
  endtask

  task automatic test_limits();
    point_t p;
    configure(1, 1000, 1, 500, 0, 0, 0);
    send_point(point_at(1, 0, -1000, 500, 0, 0));
    send_point(point_at(2, 0, 1000, -500, 0, 1));
    send_point(point_at(1, 0, 0, 0, 0, 0));
    p = point_at(2, 0, 0, 0, 0, 1);
    p.vel[1] = 1001;
    send_point(p);
    p = point_at(1, 0, 0, 0, 0, 1);
    p.acc[2] = -501;
    send_point(p);
    // full-scale limits: only the most negative value exceeds
    configure(1, LIM_MAX, 1, LIM_MAX, 0, 0, 0);
    send_point(point_at(1, 0, 32'h7fff_ffff, 32'h8000_0001, 0, 0));
    send_point(point_at(2, 0, 0, 32'h8000_0000, 0, 1));
    // zero limits
    configure(1, 0, 1, 0, 0, 0, 0);
    send_point(point_at(1, 0, 0, 0, 0, 0));
    p = point_at(2, 0, 0, 0, 0, 1);
    p.vel[0] = 1;
    send_point(p);
  endtask

  task automatic test_derivative();
    configure(0, 0, 0, 0, 1, 0, 0);
    // position rate off by one unit on the second pair
    send_point(point_at(0, 0, 2, 0, 0, 0));
    send_point(point_at(10, 20, 2, 0, 0, 0));
    send_point(point_at(20, 41, 2, 0, 0, 1));
    // velocity rate against mean acceleration, zero tolerance
    send_point(point_at(0, 0, 0, 1, 0, 0));
    send_point(point_at(4, 0, 0, 1, 0, 1));
    // the same pair sits exactly on a tolerance of one
    configure(0, 0, 0, 0, 1, 0, 1);
    send_point(point_at(0, 0, 0, 1, 0, 0));
    send_point(point_at(4, 0, 0, 1, 0, 1));
    // full-scale values, dt and tolerances
    configure(0, 0, 0, 0, 1, LIM_MAX, LIM_MAX);
    send_point(point_at(0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    send_point(point_at(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 1));
    // point error beats an earlier pair error; non-rising pair untested
    configure(0, 0, 0, 0, 1, 0, 0);
    send_point(point_at(0, 0, 0, 0, 0, 0));
    send_point(point_at(1, 100, 0, 0, 0, 0));
    send_point(point_at(1, -5, 7, 3, 0, 1));
  endtask

  // register writes between points of one trajectory
  task automatic test_midstream_config();
    configure(0, 0, 0, 0, 1, 0, 0);
    send_point(point_at(0, 0, 0, 0, 0, 0));
    send_point(point_at(3, 9, 0, 0, 0, 0));
    wait_idle();
    // recorded pair error survives clearing the enable
    write_reg(tpv_pkg::REG_DERIV_EN, en_word(0));
    write_reg(REG_SPARE, LIM_MAX);
    send_point(point_at(6, 9, 0, 0, 0, 1));
    // speed check switched on after the first point
    send_point(point_at(0, 0, 5, 0, 0, 0));
    wait_idle();
    write_reg(tpv_pkg::REG_MAX_SPEED, 4);
    write_reg(tpv_pkg::REG_SPEED_EN, en_word(1));
    send_point(point_at(1, 0, 5, 0, 0, 1));
  endtask

  // random trajectories, mostly physically consistent, under random settings
  task automatic test_random_traffic();
    int     sent, len;
    bit     noise;
    longint pos[tpv_pkg::NUM_AXES], vel[tpv_pkg::NUM_AXES], acc[tpv_pkg::NUM_AXES];
    longint na, nv, stamp_now, dt;
    point_t p;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      configure($urandom_range(0, 1), pick_limit(1 << 20), $urandom_range(0, 1),
                pick_limit(1 << 14), $urandom_range(0, 3) != 0, pick_limit(64),
                pick_limit(64));
      quiet = ($urandom_range(0, 7) == 0);
      repeat ($urandom_range(4, 10)) begin
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        noise     = ($urandom_range(0, 4) == 0);
        stamp_now = $urandom_range(0, 1000);
        for (int k = 0; k < tpv_pkg::NUM_AXES; k++) begin
          pos[k] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          vel[k] = longint'($urandom_range(0, 1 << 13)) - (1 << 12);
          acc[k] = longint'($urandom_range(0, 1 << 9)) - (1 << 8);
        end
        for (int i = 0; i < len; i++) begin
          if (i > 0) begin
            if (noise) dt = longint'($urandom);
            else if ($urandom_range(0, 9) == 0) dt = $urandom_range(17, 64);
            else dt = $urandom_range(1, 16);
            // occasional stamp that does not rise
            if ($urandom_range(0, 29) == 0) dt = -longint'($urandom_range(0, 3));
            stamp_now += dt;
            for (int k = 0; k < tpv_pkg::NUM_AXES; k++) begin
              na     = acc[k] + jitter(50, 16);
              nv     = vel[k] + ((acc[k] + na) * dt) / 2 + jitter(30, 40);
              pos[k] = pos[k] + ((vel[k] + nv) * dt) / 2 + jitter(30, 40);
              vel[k] = nv;
              acc[k] = na;
            end
          end
          for (int k = 0; k < tpv_pkg::NUM_AXES; k++) begin
            p.pos[k] = pos[k][tpv_pkg::FIELD_W-1:0];
            p.vel[k] = vel[k][tpv_pkg::FIELD_W-1:0];
            p.acc[k] = acc[k][tpv_pkg::FIELD_W-1:0];
          end
          p.stamp = stamp_now[tpv_pkg::STAMP_W-1:0];
          p.bad   = ($urandom_range(0, 32) == 0);
          p.fin   = (i == len - 1);
          if (noise) begin
            p.pos = {$urandom, $urandom, $urandom};
            p.vel = {$urandom, $urandom, $urandom};
            p.acc = {$urandom, $urandom, $urandom};
            p.bad = ($urandom_range(0, 9) == 0);
          end
          send_point(p);
          sent++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // sequence
  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_point_errors();
    test_limits();
    test_derivative();
    test_midstream_config();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
